FILE: design/aes_pkg.sv
// shared types, tables and round helpers for the aes encrypt unit
package aes_pkg;

	localparam int KeyWordsMax = 60;
	localparam int KeyWordsIdxW = 6;

	localparam logic [1:0] KEY_SIZE_128 = 2'd0;
	localparam logic [1:0] KEY_SIZE_192 = 2'd1;
	localparam logic [1:0] KEY_SIZE_256 = 2'd2;

	localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
	localparam logic [2:0] CFG_KEY_PART0 = 3'd1;
	localparam logic [2:0] CFG_KEY_PART1 = 3'd2;
	localparam logic [2:0] CFG_KEY_PART2 = 3'd3;
	localparam logic [2:0] CFG_KEY_PART3 = 3'd4;

	typedef struct packed {
		logic [3:0] nk;
		logic [3:0] nr;
	} geom_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [0:255];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// key size three saturates to 256 bits
	function automatic geom_t key_geom(input logic [1:0] ks);
		geom_t g;
		case (ks)
			KEY_SIZE_128: begin g.nk = 4'd4; g.nr = 4'd10; end
			KEY_SIZE_192: begin g.nk = 4'd6; g.nr = 4'd12; end
			default: begin g.nk = 4'd8; g.nr = 4'd14; end
		endcase
		return g;
	endfunction

endpackage

FILE: design/aes_key_expand.sv
// key schedule: one round-key word per cycle into the round-key memory
module aes_key_expand (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [1:0]                          key_size,
	input  logic [255:0]                        key,
	output logic                                done,
	output logic                                wr_en,
	output logic [aes_pkg::KeyWordsIdxW-1:0]    wr_addr,
	output logic [31:0]                         wr_data
);
	import aes_pkg::*;

	geom_t g;
	logic busy_q;
	logic [KeyWordsIdxW-1:0] idx_q;
	logic [3:0] mod_q;        // idx mod nk
	logic [7:0] rcon_q;
	logic [31:0] win_q [0:7]; // last nk words, win_q[0] oldest
	logic [31:0] t, nw, prev, back;
	logic [5:0] total;

	assign g = key_geom(key_size);
	assign total = {g.nr, 2'b00} + 6'd4;
	assign prev = win_q[g.nk[3:0] == 4'd4 ? 3 : (g.nk == 4'd6 ? 5 : 7)];
	assign back = win_q[0];

	always_comb begin
		t = prev;
		if (mod_q == 4'd0)
			t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
		else if (g.nk == 4'd8 && mod_q == 4'd4)
			t = sub_word(prev);
		nw = back ^ t;
	end

	assign wr_en = busy_q;
	assign wr_addr = idx_q;
	assign wr_data = (idx_q < KeyWordsIdxW'(g.nk)) ? key[255 - 32*idx_q[2:0] -: 32] : nw;
	assign done = busy_q && ({1'b0, idx_q} == {1'b0, total} - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			mod_q <= '0;
			rcon_q <= 8'h01;
		end else if (go) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			mod_q <= '0;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (done) busy_q <= 1'b0;
			if (mod_q == g.nk - 4'd1) begin
				mod_q <= '0;
			end else begin
				mod_q <= mod_q + 4'd1;
			end
			if (idx_q >= KeyWordsIdxW'(g.nk) && mod_q == 4'd0)
				rcon_q <= xtime(rcon_q);
		end
	end

	// shift window: drop oldest of the nk live words
	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < 7; i++) begin
				if (i == g.nk - 1) win_q[i] <= wr_data;
				else win_q[i] <= win_q[i+1];
			end
			if (g.nk == 4'd8) win_q[7] <= wr_data;
		end
	end
endmodule

FILE: design/aes_round.sv
// one aes round: subbytes, shiftrows, optional mixcolumns, addroundkey
module aes_round (
	input  logic [127:0] state_in,
	input  logic [127:0] round_key,
	input  logic         last,
	output logic [127:0] state_out
);
	import aes_pkg::*;

	logic [7:0] s [0:15];
	logic [7:0] t [0:15];
	logic [7:0] m [0:15];
	logic [7:0] a0, a1, a2, a3, all;

	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = state_in[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[c*4 + r] = sbox(s[((c + r) % 4)*4 + r]);
		for (int c = 0; c < 4; c++) begin
			a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[c*4]   = last ? a0 : a0 ^ all ^ xtime(a0 ^ a1);
			m[c*4+1] = last ? a1 : a1 ^ all ^ xtime(a1 ^ a2);
			m[c*4+2] = last ? a2 : a2 ^ all ^ xtime(a2 ^ a3);
			m[c*4+3] = last ? a3 : a3 ^ all ^ xtime(a3 ^ a0);
		end
		for (int i = 0; i < 16; i++) state_out[127 - 8*i -: 8] = m[i] ^ round_key[127 - 8*i -: 8];
	end
endmodule

FILE: design/aes_block_encrypt_unit.sv
// top level: aes-128/192/256 block encryption with shared round logic
// One 128-bit block per transaction: raise start while busy is low. The first block after
// reset or after a write to the key size or a key part first runs the key schedule, one
// round-key word per cycle (44, 52 or 60 words). Each block then keeps busy high while it
// fetches round key 0, adds it and then runs one round per cycle, with one round-key read
// per round from a key memory of 15 rows of four words and one shared round datapath. The
// ciphertext shows on the output ports with done high for exactly one cycle, the first
// cycle in which busy is low; a new block may already be started in that cycle. The
// receiver cannot stall the result, so it must take it in that cycle. Configuration writes
// must only be made while the unit is idle and no block is being started.
module aes_block_encrypt_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plaintext_high,
	input  logic [63:0] plaintext_low,
	output logic        done,
	output logic [63:0] ciphertext_high,
	output logic [63:0] ciphertext_low,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import aes_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_KEYS = 3'd1;
	localparam logic [2:0] ST_RD0  = 3'd2; // fetch round key 0
	localparam logic [2:0] ST_RUN  = 3'd3;

	logic [2:0] state_q;
	logic [1:0] key_size_q;
	logic [63:0] key_part_q [0:3];
	logic keys_ready_q;
	logic [127:0] pt_q, st_q;
	logic [3:0] rnd_q;
	geom_t g;

	// round-key memory, four words per row so one read yields a round key
	logic [127:0] rk_mem [0:14];
	logic [127:0] rk_q;
	logic [3:0] rd_row;

	logic kx_go, kx_done, kx_we;
	logic [KeyWordsIdxW-1:0] kx_addr;
	logic [31:0] kx_data;
	logic [95:0] row_acc_q;
	logic [127:0] rnd_out;

	assign g = key_geom(key_size_q);
	assign busy = (state_q != ST_IDLE);
	assign kx_go = (state_q == ST_IDLE) && start && !keys_ready_q;

	aes_key_expand u_kx (
		.clk(clk), .arst_n(arst_n), .go(kx_go), .key_size(key_size_q),
		.key({key_part_q[0], key_part_q[1], key_part_q[2], key_part_q[3]}),
		.done(kx_done), .wr_en(kx_we), .wr_addr(kx_addr), .wr_data(kx_data)
	);

	// rnd_q names the key row to fetch; round index lags it by one
	aes_round u_round (
		.state_in(st_q), .round_key(rk_q), .last(rnd_q == g.nr + 4'd1), .state_out(rnd_out)
	);

	// gather words into a row and write it on the fourth word
	always_ff @(posedge clk) begin
		if (kx_we) begin
			case (kx_addr[1:0])
				2'd0: row_acc_q[95:64] <= kx_data;
				2'd1: row_acc_q[63:32] <= kx_data;
				2'd2: row_acc_q[31:0] <= kx_data;
				default: rk_mem[kx_addr[5:2]] <= {row_acc_q, kx_data};
			endcase
		end
	end

	assign rd_row = (state_q == ST_RUN) ? rnd_q : 4'd0;
	always_ff @(posedge clk) rk_q <= rk_mem[rd_row];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_size_q <= KEY_SIZE_128;
			for (int i = 0; i < 4; i++) key_part_q[i] <= '0;
			keys_ready_q <= 1'b0;
			rnd_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_SIZE: begin key_size_q <= cfg_data[1:0]; keys_ready_q <= 1'b0; end
					CFG_KEY_PART0: begin key_part_q[0] <= cfg_data; keys_ready_q <= 1'b0; end
					CFG_KEY_PART1: begin key_part_q[1] <= cfg_data; keys_ready_q <= 1'b0; end
					CFG_KEY_PART2: begin key_part_q[2] <= cfg_data; keys_ready_q <= 1'b0; end
					CFG_KEY_PART3: begin key_part_q[3] <= cfg_data; keys_ready_q <= 1'b0; end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= keys_ready_q ? ST_RD0 : ST_KEYS;
				end
				ST_KEYS: begin
					if (kx_done) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					rnd_q <= 4'd1;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// first cycle adds key 0, then one round per cycle
					if (rnd_q == g.nr + 4'd1) begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						rnd_q <= rnd_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) pt_q <= {plaintext_high, plaintext_low};
		if (state_q == ST_RUN) begin
			if (rnd_q == 4'd1) st_q <= pt_q ^ rk_q;
			else st_q <= rnd_out;
		end
	end

	assign ciphertext_high = st_q[127:64];
	assign ciphertext_low = st_q[63:0];
endmodule

FILE: test/aes_encrypt_checker.sv
// checker for the aes encrypt unit: tracks configuration, predicts ciphertext, compares results
module aes_encrypt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] plaintext_high,
	input  logic [63:0] plaintext_low,
	input  logic        done,
	input  logic [63:0] ciphertext_high,
	input  logic [63:0] ciphertext_low,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import aes_pkg::*;

	logic [7:0]  sb [0:255];
	logic [1:0]  ks_reg;
	logic [63:0] kp [0:3];
	logic [31:0] rkw [0:59];
	logic [127:0] cipher_q [$];

	initial begin
		sb = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
	end

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// fresh schedule from the current key registers; the store is rebuilt per block
	task automatic build_schedule(output int nr);
		int nk;
		logic [31:0] t;
		logic [7:0] rc;
		int eff;
		eff = (ks_reg == 2'd3) ? 2 : int'(ks_reg);
		nk = 4 + 2 * eff;
		nr = 10 + 2 * eff;
		for (int i = 0; i < nk; i++)
			rkw[i] = i[0] ? kp[i / 2][31:0] : kp[i / 2][63:32];
		rc = 8'h01;
		for (int i = nk; i < 4 * (nr + 1); i++) begin
			t = rkw[i - 1];
			if (i % nk == 0) begin
				t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = dbl(rc);
			end else if (nk > 6 && i % nk == 4) begin
				t = subst_word(t);
			end
			rkw[i] = rkw[i - nk] ^ t;
		end
	endtask

	function automatic logic [127:0] encrypt_block(input logic [127:0] pt, input int nr);
		logic [7:0] s [0:15];
		logic [7:0] u [0:15];
		logic [7:0] a0, a1, a2, a3, al;
		for (int i = 0; i < 16; i++)
			s[i] = pt[127 - 8 * i -: 8];
		for (int rd = 0; rd <= nr; rd++) begin
			if (rd > 0) begin
				// byte substitution with row shift
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						u[c * 4 + r] = sb[s[((c + r) % 4) * 4 + r]];
				s = u;
				if (rd < nr) begin
					for (int c = 0; c < 4; c++) begin
						a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
						al = a0 ^ a1 ^ a2 ^ a3;
						s[c*4]   = a0 ^ al ^ dbl(a0 ^ a1);
						s[c*4+1] = a1 ^ al ^ dbl(a1 ^ a2);
						s[c*4+2] = a2 ^ al ^ dbl(a2 ^ a3);
						s[c*4+3] = a3 ^ al ^ dbl(a3 ^ a0);
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[c * 4 + r] ^= rkw[rd * 4 + c][31 - 8 * r -: 8];
		end
		for (int i = 0; i < 16; i++)
			encrypt_block[127 - 8 * i -: 8] = s[i];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = cipher_q.size();

	initial begin
		fail_count = 0;
		ks_reg = '0;
		for (int i = 0; i < 4; i++) kp[i] = '0;
	end

	always @(posedge clk) begin
		int nr;
		logic [127:0] want;
		if (arst_n) begin
			if (done) begin
				if (cipher_q.size() == 0) begin
					$display("unexpected ciphertext %h%h at %0t", ciphertext_high,
						ciphertext_low, $realtime);
					fail_count++;
				end else begin
					want = cipher_q.pop_front();
					if (ciphertext_high !== want[127:64])
						report_mismatch("ciphertext_high", ciphertext_high, want[127:64]);
					if (ciphertext_low !== want[63:0])
						report_mismatch("ciphertext_low", ciphertext_low, want[63:0]);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_SIZE:  ks_reg = cfg_data[1:0];
					CFG_KEY_PART0: kp[0] = cfg_data;
					CFG_KEY_PART1: kp[1] = cfg_data;
					CFG_KEY_PART2: kp[2] = cfg_data;
					CFG_KEY_PART3: kp[3] = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				build_schedule(nr);
				cipher_q.push_back(encrypt_block({plaintext_high, plaintext_low}, nr));
			end
		end
	end
endmodule

FILE: test/testbench.sv
// top of the aes encrypt unit testbench: clock, reset, key settings, plaintext stimulus, verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import aes_pkg::*;

	localparam int IdleLimit = 5000;
	localparam logic [2:0] CfgIndexUnused = 3'd7;
	localparam logic [1:0] KeySizeThree = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] plaintext_high;
	logic [63:0] plaintext_low;
	logic        done;
	logic [63:0] ciphertext_high;
	logic [63:0] ciphertext_low;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	int          idle_pct;
	int          quiet_cycles;

	aes_block_encrypt_unit dut (.*);

	aes_encrypt_checker checker_inst (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// one register write, only from an idle block; the caller drops cfg_we after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// drop start, wait for the last result, then a margin for the unit to settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3);
		drain();
		write_reg(CFG_KEY_SIZE, {62'h0, ks});
		write_reg(CFG_KEY_PART0, k0);
		write_reg(CFG_KEY_PART1, k1);
		write_reg(CFG_KEY_PART2, k2);
		write_reg(CFG_KEY_PART3, k3);
		cfg_we <= 1'b0;
	endtask

	// one transaction; start stays high after acceptance and is dropped by the next idle gap
	// or by drain, while busy keeps the unit from taking it again
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		plaintext_high <= hi;
		plaintext_low <= lo;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic random_key();
		load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
	endtask

	initial begin
		logic [63:0] pat;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		plaintext_high = '0;
		plaintext_low = '0;
		idle_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key (all zero, 128 bit) before any write
		send_block('0, '0);
		// fips-197 appendix vectors for each key length
		load_key(KEY_SIZE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block('1, '1);
		load_key(KEY_SIZE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, '1);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block('0, '1);
		load_key(KEY_SIZE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block('1, '0);
		// key size three saturates to 256
		load_key(KeySizeThree, '1, '1, '1, '1);
		send_block('0, '0);
		send_block(64'h8000000000000001, 64'h0123456789abcdef);
		// a write to an unused index is ignored
		drain();
		write_reg(CfgIndexUnused, '1);
		cfg_we <= 1'b0;
		send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		// key change between blocks without a size change
		drain();
		write_reg(CFG_KEY_PART0, '0);
		cfg_we <= 1'b0;
		send_block('1, '1);
		load_key(KEY_SIZE_128, '1, '1, '0, '0);
		for (int b = 0; b < 64; b += 16) begin
			pat = 64'hffff << b;
			send_block(pat, ~pat);
		end

		// random phases over several idling levels and key settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 60;
				2: idle_pct = 0;
				default: idle_pct = 15;
			endcase
			random_key();
			for (int n = 0; n < 95; n++) begin
				send_block(rand64(), rand64());
				// hold off until everything has come back
				if (n == 40) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
